FILE: hw/rtl/sse_pkg.sv
// Shared constants and types for the selection sort engine.
// No dependencies; the interfaces, sse_min_unit, the engine and the testbench import it.
package sse_pkg;

   localparam int unsigned DATA_W           = 32;
   localparam int unsigned MAX_ELEMENTS_DEF = 16;

   // Commands from the sequencer to the shared minimum unit
   typedef struct packed {
      logic load;   // take the candidate as the new running minimum
      logic step;   // compare the candidate against the running minimum
   } min_ctl_type;

endpackage

FILE: hw/rtl/sse_req_if.sv
// Input channel of the selection sort engine: valid/ready plus one element.
// Depends on sse_pkg.
interface sse_req_if import sse_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] value;
   logic              is_last;

   modport source (output valid, output value, output is_last, input ready);
   modport sink   (input valid, input value, input is_last, output ready);
endinterface

FILE: hw/rtl/sse_rsp_if.sv
// Result channel of the selection sort engine: valid/ready plus one sorted element.
// Depends on sse_pkg.
interface sse_rsp_if import sse_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] sorted_value;
   logic              last_out;
   logic              overflow;

   modport source (output valid, output sorted_value, output last_out, output overflow,
                   input ready);
   modport sink   (input valid, input sorted_value, input last_out, input overflow,
                   output ready);
endinterface

FILE: hw/rtl/sse_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sse_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/sse_min_unit.sv
// Shared signed compare unit holding the running minimum and its index.
// Depends on sse_pkg (min_ctl_type, DATA_W).
module sse_min_unit import sse_pkg::*; #(
   parameter int unsigned IDX_W = 4
) (
   input  logic              clock,
   input  min_ctl_type       ctl,
   input  logic [DATA_W-1:0] cand_value,
   input  logic [IDX_W-1:0]  cand_index,
   output logic [DATA_W-1:0] min_value,
   output logic [IDX_W-1:0]  min_index
);

   logic [DATA_W-1:0] min_value_ff, min_value_in;
   logic [IDX_W-1:0]  min_index_ff, min_index_in;
   logic              cand_less;

   // strict less-than keeps the earliest of equal elements
   assign cand_less = $signed(cand_value) < $signed(min_value_ff);

   always_comb begin
      min_value_in = min_value_ff;
      min_index_in = min_index_ff;
      if (ctl.load || (ctl.step && cand_less)) begin
         min_value_in = cand_value;
         min_index_in = cand_index;
      end
   end

   always_ff @(posedge clock) begin
      min_value_ff <= min_value_in;
      min_index_ff <= min_index_in;
   end

   assign min_value = min_value_ff;
   assign min_index = min_index_ff;

endmodule

FILE: hw/rtl/selection_sort_engine_unit.sv
// Channel   | Dir | Handshake   | Beat contents
// req_chan  | in  | valid/ready | value (signed 32), is_last
// rsp_chan  | out | valid/ready | sorted_value (signed 32), last_out, overflow
//
// Elements are taken one beat per cycle until the beat with is_last.
// For each position of a stored set, the engine steps through load, first read,
// one compare per remaining entry through the shared minimum unit, and result;
// the result waits through any rsp stall before the next position is loaded.
// req_chan is not ready from the last beat until the final result is taken.
// Reset is synchronous and needs no clearing pass; the store data is used only
// where the current set has written it.
// Depends on sse_pkg, sse_req_if, sse_rsp_if, sse_ram and sse_min_unit.
module selection_sort_engine_unit import sse_pkg::*; #(
   parameter int unsigned MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   sse_req_if.sink   req_chan,
   sse_rsp_if.source rsp_chan
);

   localparam int unsigned IDX_W = $clog2(MAX_ELEMENTS);
   localparam int unsigned CNT_W = $clog2(MAX_ELEMENTS + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_ELEMENTS);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   typedef enum logic [4:0] {
      ST_COLLECT = 5'b00001,
      ST_LOAD    = 5'b00010,
      ST_FIRST   = 5'b00100,
      ST_SCAN    = 5'b01000,
      ST_EMIT    = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              dropped_ff, dropped_in;
   logic [IDX_W-1:0]  pos_ff, pos_in;
   logic [IDX_W-1:0]  k_ff, k_in;
   logic [DATA_W-1:0] pos_val_ff, pos_val_in;

   logic              req_beat, rsp_beat;
   logic              ram_wr_en;
   logic [IDX_W-1:0]  ram_wr_addr, ram_rd_addr;
   logic [DATA_W-1:0] ram_wr_data, ram_rd_data;
   min_ctl_type       min_ctl;
   logic [IDX_W-1:0]  min_cand_index;
   logic [DATA_W-1:0] min_value;
   logic [IDX_W-1:0]  min_index;
   logic [CNT_W-1:0]  pos_next_cnt, k_next_cnt;
   logic              pos_is_last;

   assign req_beat     = req_chan.valid && req_chan.ready;
   assign rsp_beat     = rsp_chan.valid && rsp_chan.ready;
   assign pos_next_cnt = CNT_W'(pos_ff) + CNT_ONE;
   assign k_next_cnt   = CNT_W'(k_ff) + CNT_ONE;
   assign pos_is_last  = (pos_next_cnt == count_ff);

   sse_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_ELEMENTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   sse_min_unit #(
      .IDX_W (IDX_W)
   ) u_min (
      .clock      (clock),
      .ctl        (min_ctl),
      .cand_value (ram_rd_data),
      .cand_index (min_cand_index),
      .min_value  (min_value),
      .min_index  (min_index)
   );

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      dropped_in     = dropped_ff;
      pos_in         = pos_ff;
      k_in           = k_ff;
      pos_val_in     = pos_val_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = count_ff[IDX_W-1:0];
      ram_wr_data    = req_chan.value;
      ram_rd_addr    = pos_ff;
      min_ctl        = '0;
      min_cand_index = k_ff;

      unique case (state_ff)
         ST_COLLECT: begin
            if (req_beat) begin
               if (count_ff < CNT_FULL) begin
                  ram_wr_en = 1'b1;
                  count_in  = count_ff + CNT_ONE;
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_chan.is_last) begin
                  pos_in   = '0;
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            ram_rd_addr = pos_ff;
            state_in    = ST_FIRST;
         end
         ST_FIRST: begin
            // read data is the entry at pos: it seeds the minimum
            min_ctl.load   = 1'b1;
            min_cand_index = pos_ff;
            pos_val_in     = ram_rd_data;
            ram_rd_addr    = pos_next_cnt[IDX_W-1:0];
            k_in           = pos_next_cnt[IDX_W-1:0];
            state_in       = pos_is_last ? ST_EMIT : ST_SCAN;
         end
         ST_SCAN: begin
            min_ctl.step   = 1'b1;
            min_cand_index = k_ff;
            ram_rd_addr    = k_next_cnt[IDX_W-1:0];
            if (k_next_cnt == count_ff) begin
               state_in = ST_EMIT;
            end else begin
               k_in = k_next_cnt[IDX_W-1:0];
            end
         end
         ST_EMIT: begin
            // the minimum goes out; the displaced element moves to its slot
            ram_wr_en   = 1'b1;
            ram_wr_addr = min_index;
            ram_wr_data = pos_val_ff;
            if (rsp_beat) begin
               if (pos_is_last) begin
                  count_in   = '0;
                  dropped_in = 1'b0;
                  state_in   = ST_COLLECT;
               end else begin
                  pos_in   = pos_next_cnt[IDX_W-1:0];
                  state_in = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_COLLECT;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
      end
      pos_ff     <= pos_in;
      k_ff       <= k_in;
      pos_val_ff <= pos_val_in;
   end

   assign req_chan.ready        = (state_ff == ST_COLLECT);
   assign rsp_chan.valid        = (state_ff == ST_EMIT);
   assign rsp_chan.sorted_value = min_value;
   assign rsp_chan.last_out     = pos_is_last;
   assign rsp_chan.overflow     = dropped_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("element count above buffer depth");

   a_drop_only_full: assert property (@(posedge clock) disable iff (reset)
      dropped_ff |-> (count_ff == CNT_FULL))
      else $error("drop flagged while buffer not full");

   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> ((k_ff > pos_ff) && (CNT_W'(k_ff) < count_ff)))
      else $error("scan index outside the unsorted part");

   a_min_in_tail: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (min_index >= pos_ff))
      else $error("minimum taken from the sorted part");

   a_set_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_beat && rsp_chan.last_out) |=> ((count_ff == '0) && !dropped_ff))
      else $error("set state not cleared after final result");

endmodule

FILE: sim/tb_top.sv
// Testbench for selection_sort_engine_unit. It sends sets of signed elements,
// predicts the sorted beats with its own selection sort and checks every result.
// Depends on sse_pkg, sse_req_if, sse_rsp_if and the engine RTL.
module tb_top import sse_pkg::*; ();

   localparam int unsigned       SET_CAP      = MAX_ELEMENTS_DEF;
   localparam logic [DATA_W-1:0] MOST_NEG     = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic [DATA_W-1:0] MOST_POS     = {1'b0, {(DATA_W-1){1'b1}}};
   localparam int unsigned       DRAIN_CYCLES = 40;
   localparam int unsigned       RUN_LIMIT    = 2_000_000;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              is_final;
      logic              overflow;
   } sorted_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sse_req_if req_if ();
   sse_rsp_if rsp_if ();

   selection_sort_engine_unit #(.MAX_ELEMENTS(SET_CAP)) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always #2 clock = ~clock;

   // predictor state: elements of the set being collected
   logic [DATA_W-1:0] held_elements [SET_CAP];
   int unsigned       held_count   = 0;
   logic              held_dropped = 1'b0;
   sorted_beat_type   sorted_expect_q [$];

   int unsigned error_count   = 0;
   bit          idle_enable   = 1'b1;
   bit          req_was_final = 1'b0;
   int unsigned rsp_wait      = 0;

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                  input logic [DATA_W-1:0] want);
      error_count++;
      $display("mismatch at %0t: %s got %0d (0x%h) want %0d (0x%h)",
               $time, what, $signed(got), got, $signed(want), want);
   endtask

   // Stores one accepted element, or marks a drop once the set is full; on the final
   // one sorts the kept elements and queues one expected beat per kept element.
   task automatic sort_set_predict(input logic [DATA_W-1:0] v, input logic fin);
      logic [DATA_W-1:0] ordered [SET_CAP];
      logic [DATA_W-1:0] swap;
      int unsigned       low_idx;
      sorted_beat_type   beat;
      if (held_count < SET_CAP) begin
         held_elements[held_count] = v;
         held_count++;
      end else begin
         held_dropped = 1'b1;
      end
      if (fin) begin
         ordered = held_elements;
         for (int unsigned p = 0; p < held_count; p++) begin
            low_idx = p;
            // strict compare keeps the earliest of equal values
            for (int unsigned k = p + 1; k < held_count; k++)
               if ($signed(ordered[k]) < $signed(ordered[low_idx]))
                  low_idx = k;
            swap             = ordered[p];
            ordered[p]       = ordered[low_idx];
            ordered[low_idx] = swap;
         end
         for (int unsigned p = 0; p < held_count; p++) begin
            beat.value    = ordered[p];
            beat.is_final = (p + 1 == held_count);
            beat.overflow = held_dropped;
            sorted_expect_q.push_back(beat);
         end
         held_count   = 0;
         held_dropped = 1'b0;
      end
   endtask

   // Sends one element beat; valid stays high into the next beat unless a gap
   // is drawn or the set has ended.
   task automatic send_element(input logic [DATA_W-1:0] v, input logic fin);
      int unsigned gap;
      gap = idle_enable ? $urandom_range(0, 3) : 0;
      if (req_was_final && gap == 0)
         gap = 1;
      if (gap != 0) begin
         if (!req_was_final)
            req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.value   <= v;
      req_if.is_last <= fin;
      do @(posedge clock); while (!req_if.ready);
      sort_set_predict(v, fin);
      req_was_final = fin;
      if (fin)
         req_if.valid <= 1'b0;
   endtask

   function automatic logic [DATA_W-1:0] draw_value(input bit narrow);
      case ($urandom_range(0, 7))
         0:       return MOST_NEG;
         1:       return MOST_POS;
         2, 3:    return DATA_W'($urandom_range(0, 6)) - DATA_W'(3);
         default: return narrow ? DATA_W'($urandom_range(0, 3)) : DATA_W'($urandom());
      endcase
   endfunction

   task automatic test_single_extremes();
      send_element(MOST_NEG, 1'b1);
      send_element(MOST_POS, 1'b1);
   endtask

   // both signs, both extremes and repeated values in one set
   task automatic test_mixed_extremes();
      logic [DATA_W-1:0] mix [6];
      mix = '{MOST_POS, MOST_NEG, '0, '1, DATA_W'(1), MOST_NEG};
      foreach (mix[i])
         send_element(mix[i], i == 5);
   endtask

   // full buffer, then a final element that is dropped but still ends the set
   task automatic test_buffer_full();
      for (int i = 0; i <= SET_CAP; i++)
         send_element(DATA_W'(8 - i), i == SET_CAP);
   endtask

   task automatic test_random_sets(input int unsigned item_total);
      int unsigned sent;
      int unsigned set_len;
      bit          narrow;
      sent = 0;
      while (sent < item_total) begin
         case ($urandom_range(0, 9))
            0:       set_len = 1;
            7:       set_len = SET_CAP;
            8, 9:    set_len = $urandom_range(SET_CAP + 1, SET_CAP + 8);
            default: set_len = $urandom_range(2, SET_CAP - 1);
         endcase
         idle_enable = ($urandom_range(0, 3) != 0);
         narrow      = ($urandom_range(0, 3) == 0);
         for (int unsigned k = 0; k < set_len; k++)
            send_element(draw_value(narrow), k + 1 == set_len);
         sent += set_len;
      end
      idle_enable = 1'b1;
   endtask

   // result side: random stalls and the check of every accepted beat
   always @(posedge clock) begin : rsp_side
      sorted_beat_type want;
      if (reset) begin
         rsp_wait = 0;
         rsp_if.ready <= 1'b1;
      end else if (rsp_if.valid && rsp_if.ready) begin
         if (sorted_expect_q.size() == 0) begin
            report_mismatch("beat with nothing expected, sorted_value",
                            rsp_if.sorted_value, 'x);
         end else begin
            want = sorted_expect_q.pop_front();
            if (rsp_if.sorted_value !== want.value)
               report_mismatch("sorted_value", rsp_if.sorted_value, want.value);
            if (rsp_if.last_out !== want.is_final)
               report_mismatch("last_out", DATA_W'(rsp_if.last_out), DATA_W'(want.is_final));
            if (rsp_if.overflow !== want.overflow)
               report_mismatch("overflow", DATA_W'(rsp_if.overflow), DATA_W'(want.overflow));
         end
         rsp_wait = idle_enable ? $urandom_range(0, 3) : 0;
         if (rsp_wait != 0)
            rsp_if.ready <= 1'b0;
      end else if (!rsp_if.ready) begin
         if (rsp_wait > 1) begin
            rsp_wait--;
         end else begin
            rsp_wait = 0;
            rsp_if.ready <= 1'b1;
         end
      end
   end

   initial begin
      req_if.valid   = 1'b0;
      req_if.value   = '0;
      req_if.is_last = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_single_extremes();
      test_mixed_extremes();
      test_buffer_full();
      test_random_sets(390);
      while (sorted_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #(RUN_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

endmodule
